/* rtl/core/gpsd_pkg.sv */
// Package with shared constants and item types for the packet stream demultiplexer.
`timescale 1ns / 1ps
`default_nettype none
package gpsd_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ESC    = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    localparam logic CHAN_DEBUG = 1'b0;
    localparam logic CHAN_DATA  = 1'b1;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic       channel;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic       in_packet_mode;
        logic       dollar_seen;
        logic [1:0] trailer_left;
    } front_state_t;

endpackage
`default_nettype wire

/* rtl/core/gpsd_front.sv */
// Front end: tracks packet framing and classifies each byte as debugger or data traffic.
`timescale 1ns / 1ps
`default_nettype none
module gpsd_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  sink_attached,
    output gpsd_pkg::item_t            item,
    output logic                       item_valid,
    output gpsd_pkg::front_state_t     state
);
    import gpsd_pkg::*;

    front_state_t state_reg;
    front_state_t state_next;
    logic         is_ack;
    logic         is_dollar;
    logic         is_data;

    assign is_ack    = (in_byte == CH_PLUS) || (in_byte == CH_MINUS);
    assign is_dollar = (in_byte == CH_DOLLAR);

    always_comb
    begin
        state_next = state_reg;
        is_data    = 1'b0;
        if (!state_reg.in_packet_mode)
        begin
            if (is_ack || is_dollar)
            begin
                state_next.in_packet_mode = 1'b1;
                state_next.dollar_seen    = is_dollar;
                state_next.trailer_left   = 2'd0;
            end
            else
            begin
                is_data = 1'b1;
            end
        end
        else if (!state_reg.dollar_seen)
        begin
            if (is_dollar)
            begin
                state_next.trailer_left = 2'd0;
                state_next.dollar_seen  = 1'b1;
            end
            else if (!is_ack)
            begin
                state_next.trailer_left   = 2'd0;
                state_next.in_packet_mode = 1'b0;
                is_data                   = 1'b1;
            end
        end
        else
        begin
            if (state_reg.trailer_left == 2'd0)
            begin
                if (in_byte == CH_HASH)
                begin
                    state_next.trailer_left = 2'd2;
                end
            end
            else
            begin
                state_next.trailer_left = state_reg.trailer_left - 2'd1;
                if (state_reg.trailer_left == 2'd1)
                begin
                    state_next.dollar_seen = 1'b0;
                end
            end
        end
    end

    assign item.channel = is_data ? CHAN_DATA : CHAN_DEBUG;
    assign item.data    = in_byte;
    assign item_valid   = accept && (!is_data || sink_attached);
    assign state        = state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/gpsd_queue.sv */
// Short register queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none
module gpsd_queue #(
    parameter int DEPTH = gpsd_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire gpsd_pkg::item_t wr_item,
    input  wire logic            rd_en,
    output gpsd_pkg::item_t      rd_item,
    output logic                 q_full,
    output logic                 q_empty
);
    import gpsd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr;
    logic              do_rd;

    assign q_full  = (count_reg == FULL_CNT);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/gpsd_back.sv */
// Back end: removes escapes from data items and holds the result register.
`timescale 1ns / 1ps
`default_nettype none
module gpsd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_empty,
    input  wire gpsd_pkg::item_t q_item,
    output logic                 q_pop,
    input  wire logic            pop,
    output logic                 empty,
    output logic                 channel,
    output logic [7:0]           out_byte
);
    import gpsd_pkg::*;

    logic        out_valid_reg;
    logic        out_channel_reg;
    logic [7:0]  out_byte_reg;
    logic        esc_reg;
    logic        take;
    logic        is_prefix;

    assign take      = !q_empty && (!out_valid_reg || pop);
    assign q_pop     = take;
    assign is_prefix = (q_item.channel == CHAN_DATA) && !esc_reg && (q_item.data == CH_ESC);

    always_ff @(posedge clk)
    begin
        if (take && !is_prefix)
        begin
            out_channel_reg <= q_item.channel;
            if ((q_item.channel == CHAN_DATA) && esc_reg)
            begin
                out_byte_reg <= q_item.data ^ ESC_XOR;
            end
            else
            begin
                out_byte_reg <= q_item.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            esc_reg       <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= !is_prefix;
                if (q_item.channel == CHAN_DATA)
                begin
                    esc_reg <= is_prefix;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty    = !out_valid_reg;
    assign channel  = out_channel_reg;
    assign out_byte = out_byte_reg;

endmodule
`default_nettype wire

/* rtl/core/gdb_packet_stream_demux.sv */
// Top level of the packet stream demultiplexer: front end, item queue and back end.
//
// Usage: bytes enter through a queue-style port (push, full, in_byte, sink_attached);
// an item is taken at a clock edge with push high and full low. Results leave through
// a queue-style port (empty, pop, channel, out_byte); the oldest result is shown while
// empty is low and is taken at an edge with pop high. Channel 0 carries debugger packet
// bytes as received, channel 1 carries out-of-band data bytes with escapes removed.
// A data byte with no sink attached, and an escape prefix, produce no result.
// Throughput is one byte per cycle on both sides while full is low and results are
// popped. A byte is classified combinationally when accepted and written to the
// internal queue; from there it moves into the result register. The internal
// queue holds QUEUE_DEPTH items; when the receiver stops popping, the queue fills and
// full is raised, then drops as soon as an entry is freed.
// Reset clears the framing state to data mode, clears the escape flag, empties the
// queue and the result register; no result is shown until a byte is accepted.
`timescale 1ns / 1ps
`default_nettype none
module gdb_packet_stream_demux #(
    parameter int QUEUE_DEPTH = gpsd_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  in_byte,
    input  wire logic        sink_attached,
    output logic             empty,
    input  wire logic        pop,
    output logic             channel,
    output logic [7:0]       out_byte
);
    import gpsd_pkg::*;

    logic         accept;
    item_t        front_item;
    logic         front_valid;
    front_state_t front_state;
    item_t        q_item;
    logic         q_pop;
    logic         q_empty;

    assign accept = push && !full;

    gpsd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_byte),
        .sink_attached (sink_attached),
        .item          (front_item),
        .item_valid    (front_valid),
        .state         (front_state)
    );

    gpsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_item (front_item),
        .rd_en   (q_pop),
        .rd_item (q_item),
        .q_full  (full),
        .q_empty (q_empty)
    );

    gpsd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .channel  (channel),
        .out_byte (out_byte)
    );

`ifndef SYNTHESIS
    a_trailer_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (front_state.trailer_left != 2'd0) |-> front_state.dollar_seen)
        else $error("Checksum trailer counted outside an open packet.");

    a_dollar_in_mode: assert property (@(posedge clk) disable iff (!rst_n)
        front_state.dollar_seen |-> front_state.in_packet_mode)
        else $error("Packet open while in data mode.");

    a_trailer_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_state.trailer_left != 2'd3)
        else $error("Checksum trailer counter out of range.");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        front_valid |-> !full)
        else $error("Classified item written while the queue is full.");
`endif

endmodule
`default_nettype wire
